// ===== rtl/acd_pkg.sv =====
package acd_pkg;

  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_SEEDED = 2'd1;
  localparam logic [1:0] ST_UNSEED = 2'd2;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  localparam int unsigned SEED_WORDS = 6;
  localparam int unsigned NROUNDS    = 14;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // one cipher round on a big-endian 128-bit state, byte 0 at the top
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] n [16];
    logic [7:0] a0, a1, a2, a3, t;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        n[4*c+i] = sbox(b[4*((c+i)%4)+i]);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
        t = a0 ^ a1 ^ a2 ^ a3;
        n[4*c]   = a0 ^ t ^ dbl(a0 ^ a1);
        n[4*c+1] = a1 ^ t ^ dbl(a1 ^ a2);
        n[4*c+2] = a2 ^ t ^ dbl(a2 ^ a3);
        n[4*c+3] = a3 ^ t ^ dbl(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = n[i];
    return r;
  endfunction

endpackage

// ===== rtl/aes256_ctr_drbg_unit.sv =====
// AES-256 CTR_DRBG without derivation function. Seed transfers (operation 0)
// each store entropy_word ^ personal_word; the sixth runs an update from a zero
// key and counter and returns one acknowledge (status 1). A generate transfer
// (operation 1) returns ceil(n/8) words of keystream, n = request_bytes capped
// at MAX_REQUEST_BYTES, then updates key and counter; zero bytes gives one empty
// result with status 0, and an unseeded block answers with status 2.
// Structure: the cipher is one iterative round unit with on-the-fly key
// expansion, a load step and then 14 rounds per 16-byte block. A generate
// keeps the input closed until its output words and its update are done; the
// sixth seed word runs three update blocks, then a sweep of the seed memory,
// before its acknowledge is offered. Seed words sit in a 6-entry synchronous
// memory read back during the update. A seed word that is not the sixth
// gives no result. The input stays closed while a result waits.
module aes256_ctr_drbg_unit #(
  parameter int unsigned MAX_REQUEST_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_entropy_word,
  input  logic [63:0] in_personal_word,
  input  logic [9:0]  in_request_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_random_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last_flag,
  output logic [1:0]  out_status
);

  localparam logic [9:0] MAXB = 10'(MAX_REQUEST_BYTES);
  localparam int unsigned SEED_WORDS_C = acd_pkg::SEED_WORDS;

  typedef enum logic [3:0] {
    S_IDLE, S_SEEDW, S_KEYINIT, S_ROUND, S_EMIT0, S_UPDRD, S_UPDDONE, S_RESP
  } state_t;

  state_t       state_r;
  logic [255:0] key_r;       // drbg key
  logic [127:0] ctr_r;       // drbg counter
  logic [2:0]   seed_idx_r;
  logic         seeded_r;
  logic [63:0]  seed_mem [SEED_WORDS_C];
  logic [63:0]  seed_rd_r;
  logic [2:0]   seed_addr_r;

  // cipher working registers
  logic [255:0] rk_r;        // sliding round key window (two round keys)
  logic [127:0] st_r;
  logic [3:0]   rnd_r;
  logic [7:0]   rcon_r;
  logic [383:0] upd_r;       // gathered update bytes
  logic [1:0]   ublk_r;      // update block index
  logic         upd_mode_r;  // 1: update blocks, 0: output blocks
  logic         seedupd_r;
  logic         zero_req_r;  // generate of zero bytes, answered after the update
  logic [9:0]   rem_r;       // bytes still to send
  logic         half_r;
  logic [127:0] blk_r;
  logic [255:0] ukey_r;      // key used through this whole request

  // out register
  logic         ov_r;
  logic [63:0]  ow_r;
  logic [3:0]   oc_r;
  logic         ol_r;
  logic [1:0]   os_r;

  assign out_valid       = ov_r;
  assign out_random_word = ow_r;
  assign out_byte_count  = oc_r;
  assign out_last_flag   = ol_r;
  assign out_status      = os_r;
  assign in_ready        = (state_r == S_IDLE) && !ov_r;

  logic in_fire;
  logic out_free;
  logic out_load;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !ov_r || out_ready;
  // out register takes a new result this cycle
  assign out_load = (state_r == S_IDLE && in_fire && in_operation == acd_pkg::OP_GEN &&
                     !seeded_r) ||
                    (state_r == S_EMIT0 && out_free) ||
                    (state_r == S_RESP && (seedupd_r || zero_req_r) && out_free);

  logic [127:0] ctr_inc;
  assign ctr_inc = ctr_r + 128'd1;

  // next round key from the window: even steps rotate/sub with rcon, odd sub only
  function automatic logic [127:0] next_rk(input logic [255:0] w, input logic odd,
                                           input logic [7:0] rc);
    logic [31:0] t, a, b, c, d;
    t = w[31:0];
    if (!odd) t = acd_pkg::subw({t[23:0], t[31:24]}) ^ {rc, 24'd0};
    else      t = acd_pkg::subw(t);
    a = w[255:224] ^ t;
    b = w[223:192] ^ a;
    c = w[191:160] ^ b;
    d = w[159:128] ^ c;
    return {a, b, c, d};
  endfunction

  // round r builds round key r+1, so odd rounds make the even keys
  logic [127:0] nrk;
  assign nrk = next_rk(rk_r, ~rnd_r[0], rcon_r);
  logic [127:0] rnd_out;
  assign rnd_out = acd_pkg::aes_round(st_r, rnd_r == 4'(acd_pkg::NROUNDS));

  // output word with bytes past the end cleared
  logic [63:0] emit_word;
  always_comb begin
    emit_word = half_r ? blk_r[63:0] : blk_r[127:64];
    for (int k = 0; k < 8; k++)
      if (rem_r <= 10'(k)) emit_word[63-8*k -: 8] = 8'h00;
  end

  // seed memory: written on a seed transfer, read during the seed update
  always_ff @(posedge clk) begin
    if (in_fire && in_operation == acd_pkg::OP_SEED)
      seed_mem[(seed_idx_r > 3'd5) ? 3'd0 : seed_idx_r] <= in_entropy_word ^ in_personal_word;
    if (seed_addr_r < 3'(SEED_WORDS_C))
      seed_rd_r <= seed_mem[seed_addr_r];
  end

  logic [9:0] req_sat;
  assign req_sat = (in_request_bytes > MAXB) ? MAXB : in_request_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= '0;
      ctr_r       <= '0;
      seed_idx_r  <= '0;
      seeded_r    <= 1'b0;
      ov_r        <= 1'b0;
      seed_addr_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_operation == acd_pkg::OP_SEED) begin
              seed_idx_r <= ((seed_idx_r > 3'd5) ? 3'd0 : seed_idx_r) + 3'd1;
              state_r    <= S_SEEDW;
            end else if (!seeded_r) begin
              ow_r <= '0; oc_r <= '0; ol_r <= 1'b1;
              os_r <= acd_pkg::ST_UNSEED;
            end else begin
              rem_r      <= req_sat;
              ukey_r     <= key_r;
              upd_mode_r <= (req_sat == 10'd0);
              zero_req_r <= (req_sat == 10'd0);
              seedupd_r  <= 1'b0;
              ublk_r     <= '0;
              state_r    <= S_KEYINIT;
            end
          end
        end
        S_SEEDW: begin
          if (seed_idx_r == 3'd6) begin
            seed_idx_r <= '0;
            key_r      <= '0;
            ctr_r      <= '0;
            ukey_r     <= '0;
            upd_mode_r <= 1'b1;
            seedupd_r  <= 1'b1;
            zero_req_r <= 1'b0;
            ublk_r     <= '0;
            state_r    <= S_KEYINIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_KEYINIT: begin
          // increment counter and whiten with the first round key
          ctr_r   <= ctr_inc;
          st_r    <= ctr_inc ^ ukey_r[255:128];
          rk_r    <= ukey_r;
          rnd_r   <= 4'd1;
          rcon_r  <= 8'h01;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          // round r uses key window lower half; window slides by one key
          st_r <= rnd_out ^ rk_r[127:0];
          rk_r <= {rk_r[127:0], nrk};
          if (rnd_r[0]) rcon_r <= acd_pkg::dbl(rcon_r);
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == 4'(acd_pkg::NROUNDS)) begin
            if (upd_mode_r) begin
              upd_r <= {upd_r[255:0], rnd_out ^ rk_r[127:0]};
              seed_addr_r <= 3'd0;
              state_r <= (ublk_r == 2'd2) ? S_UPDRD : S_KEYINIT;
              ublk_r <= ublk_r + 2'd1;
            end else begin
              blk_r   <= rnd_out ^ rk_r[127:0];
              half_r  <= 1'b0;
              state_r <= S_EMIT0;
            end
          end
        end
        S_EMIT0: begin
          if (out_free) begin
            ow_r <= emit_word;
            oc_r <= (rem_r > 10'd8) ? 4'd8 : rem_r[3:0];
            ol_r <= (rem_r <= 10'd8);
            os_r <= acd_pkg::ST_DATA;
            rem_r <= (rem_r > 10'd8) ? rem_r - 10'd8 : 10'd0;
            half_r <= 1'b1;
            if (rem_r <= 10'd8) begin
              upd_mode_r <= 1'b1;
              state_r    <= S_KEYINIT;
            end else if (half_r) begin
              state_r <= S_KEYINIT;
            end
          end
        end
        S_UPDRD: begin
          // sweep seed memory one word a cycle when seeding; read data arrives in the
          // cycle after its address, and the rotation puts each word on top
          if (seedupd_r) begin
            if (seed_addr_r != 3'd0)
              upd_r <= {upd_r[319:0], upd_r[383:320] ^ seed_rd_r};
            if (seed_addr_r == 3'(SEED_WORDS_C)) state_r <= S_UPDDONE;
            else seed_addr_r <= seed_addr_r + 3'd1;
          end else begin
            state_r <= S_UPDDONE;
          end
        end
        S_UPDDONE: begin
          key_r   <= upd_r[383:128];
          ctr_r   <= upd_r[127:0];
          state_r <= S_RESP;
        end
        S_RESP: begin
          // seeding acknowledge or the single result of a zero-byte request; else back to idle
          if (seedupd_r || zero_req_r) begin
            if (out_free) begin
              if (seedupd_r) seeded_r <= 1'b1;
              ow_r <= '0; oc_r <= '0; ol_r <= 1'b1;
              os_r <= seedupd_r ? acd_pkg::ST_SEEDED : acd_pkg::ST_DATA;
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_load) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
    end
  end

endmodule
